[design/tisau_pkg.sv]
// Shared types, register indexes and layout codes for the tiled source address unit.
`timescale 1ns / 1ps
`default_nettype none

package tisau_pkg;

  localparam int unsigned DivStages = 14;

  localparam logic [2:0] RegImageWidth  = 3'd0;
  localparam logic [2:0] RegImageHeight = 3'd1;
  localparam logic [2:0] RegTileColumns = 3'd2;
  localparam logic [2:0] RegTileRows    = 3'd3;
  localparam logic [2:0] RegTileAlign   = 3'd4;
  localparam logic [2:0] RegCompCount   = 3'd5;
  localparam logic [2:0] RegLayoutMode  = 3'd6;

  localparam logic [1:0] LayoutPlanar = 2'd0;
  localparam logic [1:0] LayoutPixel  = 2'd1;
  localparam logic [1:0] LayoutRow    = 2'd2;
  localparam logic [1:0] LayoutBad    = 2'd3;

  // Tile geometry derived from the registers, stable while the unit is not busy.
  typedef struct packed {
    logic [14:0] tw;
    logic [14:0] th;
    logic [14:0] tcols;
    logic [14:0] cov_w;
    logic [14:0] cov_h;
    logic [2:0]  cc;
    logic [1:0]  mode;
    logic [29:0] area;
    logic [33:0] size;
    logic        deg;
  } tisau_geom_t;

  typedef struct packed {
    logic [1:0]  p;
    logic [13:0] row;
    logic [13:0] col;
  } tisau_req_t;

  // Divider word: nr and nc shift out dividend bits and take in quotient bits.
  typedef struct packed {
    logic [1:0]  p;
    logic [13:0] nr;
    logic [13:0] nc;
    logic [13:0] rr;
    logic [13:0] rc;
    logic        err;
  } tisau_div_t;

  typedef struct packed {
    logic [33:0] offset;
    logic        oor;
  } tisau_rsp_t;

endpackage

`default_nettype wire

[design/tisau_if.sv]
// Request and response channel interfaces of the tiled source address unit.
`timescale 1ns / 1ps
`default_nettype none

interface tisau_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  component_pos;
  logic [13:0] row;
  logic [13:0] col;
  modport source (output valid, component_pos, row, col, input ready);
  modport sink (input valid, component_pos, row, col, output ready);
endinterface

interface tisau_rsp_if;
  logic        valid;
  logic        ready;
  logic [33:0] byte_offset;
  logic        out_of_range;
  modport source (output valid, byte_offset, out_of_range, input ready);
  modport sink (input valid, byte_offset, out_of_range, output ready);
endinterface

`default_nettype wire

[design/tisau_cfg.sv]
// Register file and sequencer that derives the tile geometry after each write.
`timescale 1ns / 1ps
`default_nettype none

module tisau_cfg import tisau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o,
  output tisau_geom_t      geom_o,
  output logic             busy_o
);

  localparam logic [3:0] StLoadW = 4'd0;
  localparam logic [3:0] StDivW  = 4'd1;
  localparam logic [3:0] StLoadH = 4'd2;
  localparam logic [3:0] StDivH  = 4'd3;
  localparam logic [3:0] StMul1  = 4'd4;
  localparam logic [3:0] StMul2  = 4'd5;
  localparam logic [3:0] StLoadA = 4'd6;
  localparam logic [3:0] StDivA  = 4'd7;
  localparam logic [3:0] StIdle  = 4'd8;

  logic [14:0] iw_q, ih_q, tcols_q, trows_q;
  logic [15:0] align_q;
  logic [2:0]  cc_q;
  logic [1:0]  mode_q;
  logic [3:0]  state_q, state_d;
  logic [5:0]  cnt_q;
  logic [32:0] dvd_q, dvd_n;
  logic [15:0] rem_q, rem_n, den_q;
  logic [16:0] trial;
  logic        last;
  logic        wr;
  logic [14:0] tw_q, th_q, cov_w_q, cov_h_q;
  logic [29:0] area_q;
  logic [32:0] content_q;
  logic [33:0] size_q;
  logic        deg_q;

  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign busy_o   = (state_q != StIdle);

  always_comb begin
    unique case (paddr_i[4:2])
      RegImageWidth:  prdata_o = {17'b0, iw_q};
      RegImageHeight: prdata_o = {17'b0, ih_q};
      RegTileColumns: prdata_o = {17'b0, tcols_q};
      RegTileRows:    prdata_o = {17'b0, trows_q};
      RegTileAlign:   prdata_o = {16'b0, align_q};
      RegCompCount:   prdata_o = {29'b0, cc_q};
      RegLayoutMode:  prdata_o = {30'b0, mode_q};
      default:        prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q    <= 15'd1;
      ih_q    <= 15'd1;
      tcols_q <= 15'd1;
      trows_q <= 15'd1;
      align_q <= 16'd0;
      cc_q    <= 3'd3;
      mode_q  <= LayoutPlanar;
    end else if (wr) begin
      unique case (paddr_i[4:2])
        RegImageWidth:  iw_q    <= pwdata_i[14:0];
        RegImageHeight: ih_q    <= pwdata_i[14:0];
        RegTileColumns: tcols_q <= pwdata_i[14:0];
        RegTileRows:    trows_q <= pwdata_i[14:0];
        RegTileAlign:   align_q <= pwdata_i[15:0];
        RegCompCount:   cc_q    <= pwdata_i[2:0];
        RegLayoutMode:  mode_q  <= pwdata_i[1:0];
        default: ;
      endcase
    end
  end

  // One restoring division step a cycle, shared by all three divisions.
  always_comb begin
    trial = {rem_q, dvd_q[32]};
    if (trial >= {1'b0, den_q}) begin
      rem_n = 16'(trial - {1'b0, den_q});
      dvd_n = {dvd_q[31:0], 1'b1};
    end else begin
      rem_n = trial[15:0];
      dvd_n = {dvd_q[31:0], 1'b0};
    end
    last = (cnt_q == 6'd32);
  end

  always_comb begin
    state_d = state_q;
    priority if (wr) begin
      state_d = StLoadW;
    end else begin
      unique case (state_q)
        StLoadW: state_d = StDivW;
        StDivW:  if (last) state_d = StLoadH;
        StLoadH: state_d = StDivH;
        StDivH:  if (last) state_d = StMul1;
        StMul1:  state_d = StMul2;
        StMul2:  state_d = StLoadA;
        StLoadA: state_d = StDivA;
        StDivA:  if (last) state_d = StIdle;
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoadW;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StDivW || state_q == StDivH || state_q == StDivA) begin
        cnt_q <= 6'(cnt_q + 6'd1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StLoadW: begin
        dvd_q <= {18'b0, iw_q};
        den_q <= {1'b0, tcols_q};
        rem_q <= '0;
      end
      StLoadH: begin
        dvd_q <= {18'b0, ih_q};
        den_q <= {1'b0, trows_q};
        rem_q <= '0;
      end
      StLoadA: begin
        dvd_q <= content_q;
        den_q <= align_q;
        rem_q <= '0;
      end
      StDivW, StDivH, StDivA: begin
        dvd_q <= dvd_n;
        rem_q <= rem_n;
      end
      default: ;
    endcase
    if (state_q == StDivW && last) tw_q <= dvd_n[14:0];
    if (state_q == StDivH && last) th_q <= dvd_n[14:0];
    if (state_q == StMul1) begin
      area_q  <= 30'(30'(tw_q) * 30'(th_q));
      cov_w_q <= 15'(30'(tw_q) * 30'(tcols_q));
      cov_h_q <= 15'(30'(th_q) * 30'(trows_q));
      deg_q   <= (tcols_q == '0) | (trows_q == '0) | (tw_q == '0) | (th_q == '0);
    end
    if (state_q == StMul2) content_q <= 33'(33'(area_q) * 33'(cc_q));
    if (state_q == StDivA && last) begin
      if (align_q != '0 && rem_n != '0) begin
        size_q <= 34'(34'(content_q) + 34'(align_q - rem_n));
      end else begin
        size_q <= 34'(content_q);
      end
    end
  end

  always_comb begin
    geom_o.tw    = tw_q;
    geom_o.th    = th_q;
    geom_o.tcols = tcols_q;
    geom_o.cov_w = cov_w_q;
    geom_o.cov_h = cov_h_q;
    geom_o.cc    = cc_q;
    geom_o.mode  = mode_q;
    geom_o.area  = area_q;
    geom_o.size  = size_q;
    geom_o.deg   = deg_q;
  end

endmodule

`default_nettype wire

[design/tisau_div.sv]
// Pipelined dual divider that splits row and column into tile index and offset.
`timescale 1ns / 1ps
`default_nettype none

module tisau_div import tisau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tisau_geom_t geom_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire tisau_req_t  req_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output tisau_div_t       data_o
);

  function automatic tisau_div_t div_step(tisau_div_t s, logic [14:0] dh, logic [14:0] dw);
    logic [14:0] tr;
    logic [14:0] tc;
    tisau_div_t  o;
    o  = s;
    tr = {s.rr, s.nr[13]};
    tc = {s.rc, s.nc[13]};
    if (tr >= dh) begin
      o.rr = 14'(tr - dh);
      o.nr = {s.nr[12:0], 1'b1};
    end else begin
      o.rr = tr[13:0];
      o.nr = {s.nr[12:0], 1'b0};
    end
    if (tc >= dw) begin
      o.rc = 14'(tc - dw);
      o.nc = {s.nc[12:0], 1'b1};
    end else begin
      o.rc = tc[13:0];
      o.nc = {s.nc[12:0], 1'b0};
    end
    return o;
  endfunction

  logic [DivStages-1:0] v_q;
  logic [DivStages:0]   en;
  tisau_div_t           s_q [DivStages];
  tisau_div_t           w0;

  // A stage may load when it is empty or its word moves on in the same cycle.
  always_comb begin
    en[DivStages] = ready_i;
    for (int k = DivStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] | en[k+1];
    end
  end

  always_comb begin
    w0.p   = req_i.p;
    w0.nr  = req_i.row;
    w0.nc  = req_i.col;
    w0.rr  = '0;
    w0.rc  = '0;
    w0.err = geom_i.deg | (geom_i.mode == LayoutBad) |
             ({1'b0, req_i.col} >= geom_i.cov_w) |
             ({1'b0, req_i.row} >= geom_i.cov_h) |
             ({1'b0, req_i.p} >= geom_i.cc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < DivStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) s_q[0] <= div_step(w0, geom_i.th, geom_i.tw);
    for (int k = 1; k < DivStages; k++) begin
      if (en[k] && v_q[k-1]) s_q[k] <= div_step(s_q[k-1], geom_i.th, geom_i.tw);
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[DivStages-1];
  assign data_o  = s_q[DivStages-1];

endmodule

`default_nettype wire

[design/tisau_addr.sv]
// Multiply and add stages that form the tile base, the in-tile offset and the sum.
`timescale 1ns / 1ps
`default_nettype none

module tisau_addr import tisau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tisau_geom_t geom_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire tisau_div_t  data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output tisau_rsp_t       rsp_o
);

  logic [2:0]  v_q;
  logic [3:0]  en;

  logic [29:0] tidx_q;
  logic [28:0] m1_q;
  logic [16:0] trc_q;
  logic [31:0] pa_q;
  logic [13:0] tc1_q;
  logic [1:0]  p1_q;
  logic        err1_q;

  logic [46:0] pl_q, ph_q;
  logic [34:0] within_q, within_d;
  logic        err2_q;

  logic [64:0] total;
  tisau_rsp_t  rsp_q;

  always_comb begin
    en[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_comb begin
    unique case (geom_i.mode)
      LayoutPlanar: within_d = 35'(35'(pa_q) + 35'(m1_q) + 35'(tc1_q));
      LayoutPixel:  within_d = 35'((35'(m1_q) + 35'(tc1_q)) * 35'(geom_i.cc)) + 35'(p1_q);
      LayoutRow:    within_d = 35'(35'(geom_i.tw) * 35'(trc_q)) + 35'(tc1_q);
      default:      within_d = '0;
    endcase
    total = 65'({ph_q, 17'b0}) + 65'(pl_q) + 65'(within_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      tidx_q <= 30'(30'(data_i.nr) * 30'(geom_i.tcols) + 30'(data_i.nc));
      m1_q   <= 29'(29'(data_i.rr) * 29'(geom_i.tw));
      trc_q  <= 17'(17'(data_i.rr) * 17'(geom_i.cc) + 17'(data_i.p));
      pa_q   <= 32'(32'(data_i.p) * 32'(geom_i.area));
      tc1_q  <= data_i.rc;
      p1_q   <= data_i.p;
      err1_q <= data_i.err;
    end
    if (en[1] && v_q[0]) begin
      pl_q     <= 47'(47'(tidx_q) * 47'(geom_i.size[16:0]));
      ph_q     <= 47'(47'(tidx_q) * 47'(geom_i.size[33:17]));
      within_q <= within_d;
      err2_q   <= err1_q;
    end
    if (en[2] && v_q[1]) begin
      // Anything beyond 34 bits is an overflow and is reported as out of range.
      if (err2_q || (total[64:34] != '0)) begin
        rsp_q.offset <= '0;
        rsp_q.oor    <= 1'b1;
      end else begin
        rsp_q.offset <= total[33:0];
        rsp_q.oor    <= 1'b0;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[2];
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

[design/tiled_interleave_source_address_unit.sv]
// Top level of the tiled interleaved image source address unit.
`timescale 1ns / 1ps
`default_nettype none

// Each request word (component, row, column) yields one response word with the byte offset
// of that 8-bit sample in a tiled, uncompressed buffer, or out_of_range with offset 0. The
// datapath is a 17-stage pipeline: 14 stages of a radix-2 divider that split row and column
// by the tile size, then three multiply and add stages. It takes one word per cycle unless
// the sequencer is busy or a stall holds it; a stall holds only the words that have no empty
// stage ahead of them. After reset and after each register write, a sequencer derives the
// tile geometry with a shared serial divider; requests are not accepted while it runs.
module tiled_interleave_source_address_unit import tisau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o,
  tisau_req_if.sink        req_i,
  tisau_rsp_if.source      rsp_o
);

  tisau_geom_t geom;
  logic        busy;
  logic        div_ready;
  logic        div_valid;
  tisau_req_t  req;
  logic        mid_valid;
  logic        mid_ready;
  tisau_div_t  mid;
  tisau_rsp_t  rsp;

  tisau_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .geom_o    (geom),
    .busy_o    (busy)
  );

  assign req.p       = req_i.component_pos;
  assign req.row     = req_i.row;
  assign req.col     = req_i.col;
  assign div_valid   = req_i.valid & !busy;
  assign req_i.ready = div_ready & !busy;

  tisau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .req_i   (req),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid)
  );

  tisau_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .rsp_o   (rsp)
  );

  assign rsp_o.byte_offset  = rsp.offset;
  assign rsp_o.out_of_range = rsp.oor;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.out_of_range |-> rsp_o.byte_offset == '0)
    else $error("out-of-range word carries a nonzero offset");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !req_i.ready)
    else $error("request accepted while geometry is being derived");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i |=> busy)
    else $error("register write did not restart the geometry sequencer");

endmodule

`default_nettype wire

[test/tisau_checker.sv]
// Checker for the tiled source address unit: predicts offsets and compares responses.
`timescale 1ns / 1ps
`default_nettype none

module tisau_checker import tisau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  input  wire logic        req_valid_i,
  input  wire logic        req_ready_i,
  input  wire logic [1:0]  req_pos_i,
  input  wire logic [13:0] req_row_i,
  input  wire logic [13:0] req_col_i,
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  input  wire logic [33:0] rsp_offset_i,
  input  wire logic        rsp_oor_i,
  output int               errors_o,
  output int               pending_o
);

  logic [14:0] img_w, img_h, tcols, trows;
  logic [15:0] align;
  logic [2:0]  ccount;
  logic [1:0]  mode;
  tisau_rsp_t  offset_q[$];

  assign pending_o = offset_q.size();

  function automatic tisau_rsp_t calc_offset(logic [1:0] p, logic [13:0] r, logic [13:0] c);
    longint unsigned tw, th, content, pad, tidx, in_tile, total;
    tisau_rsp_t res;
    res.offset = '0;
    res.oor = 1'b1;
    if (tcols == 0 || trows == 0 || mode == LayoutBad) return res;
    tw = img_w / tcols;
    th = img_h / trows;
    if (tw == 0 || th == 0) return res;
    if (c >= tw * tcols || r >= th * trows || p >= ccount) return res;
    content = tw * th * ccount;
    pad = 0;
    if (align != 0 && content % align != 0) pad = align - content % align;
    tidx = (r / th) * tcols + c / tw;
    case (mode)
      LayoutPlanar: in_tile = p * tw * th + (r % th) * tw + c % tw;
      LayoutPixel:  in_tile = ((r % th) * tw + c % tw) * ccount + p;
      default:      in_tile = tw * ((r % th) * ccount + p) + c % tw;
    endcase
    total = tidx * (content + pad) + in_tile;
    if (total >= 64'h4_0000_0000) return res;
    res.offset = total[33:0];
    res.oor = 1'b0;
    return res;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    tisau_rsp_t exp_rsp;
    if (!rst_ni) begin
      img_w = 1; img_h = 1; tcols = 1; trows = 1;
      align = 0; ccount = 3; mode = LayoutPlanar;
      offset_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (offset_q.size() == 0) begin
          report("response word with nothing expected");
        end else begin
          exp_rsp = offset_q.pop_front();
          if (rsp_oor_i !== exp_rsp.oor)
            report($sformatf("out_of_range %b, expected %b", rsp_oor_i, exp_rsp.oor));
          if (rsp_offset_i !== exp_rsp.offset)
            report($sformatf("byte offset %0d, expected %0d", rsp_offset_i, exp_rsp.offset));
        end
      end
      if (req_valid_i && req_ready_i)
        offset_q.insert(offset_q.size(), calc_offset(req_pos_i, req_row_i, req_col_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          RegImageWidth:  img_w = pwdata_i[14:0];
          RegImageHeight: img_h = pwdata_i[14:0];
          RegTileColumns: tcols = pwdata_i[14:0];
          RegTileRows:    trows = pwdata_i[14:0];
          RegTileAlign:   align = pwdata_i[15:0];
          RegCompCount:   ccount = pwdata_i[2:0];
          RegLayoutMode:  mode = pwdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[test/tb_tiled_interleave_source_address_unit.sv]
// Stimulus and verdict for the tiled source address unit testbench.
`timescale 1ns / 1ps
`default_nettype none

module tb_tiled_interleave_source_address_unit import tisau_pkg::*; ();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [4:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;
  int          errors, pending, send_idle, recv_stall, hold_cycles;
  longint      cycle_count;

  tisau_req_if req_if();
  tisau_rsp_if rsp_if();

  tiled_interleave_source_address_unit uut (
    .clk_i, .rst_ni, .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i,
    .prdata_o, .pready_o, .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  tisau_checker chk (
    .clk_i, .rst_ni, .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i,
    .pready_i(pready_o),
    .req_valid_i(req_if.valid), .req_ready_i(req_if.ready),
    .req_pos_i(req_if.component_pos), .req_row_i(req_if.row), .req_col_i(req_if.col),
    .rsp_valid_i(rsp_if.valid), .rsp_ready_i(rsp_if.ready),
    .rsp_offset_i(rsp_if.byte_offset), .rsp_oor_i(rsp_if.out_of_range),
    .errors_o(errors), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.component_pos = '0;
    req_if.row = '0;
    req_if.col = '0;
    rsp_if.ready = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("tb_tiled_interleave_source_address_unit: done, errors");
      $finish;
    end
  end

  // Registers are written only once every word in flight has come out.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    psel_i <= 1'b1; pwrite_i <= 1'b1; penable_i <= 1'b0;
    paddr_i <= {idx, 2'b00}; pwdata_i <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
  endtask

  task automatic send_word(logic [1:0] p, logic [13:0] r, logic [13:0] c);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.component_pos <= p;
    req_if.row <= r;
    req_if.col <= c;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic setup(logic [14:0] w, logic [14:0] h, logic [14:0] tc, logic [14:0] tr,
                       logic [15:0] al, logic [2:0] cc, logic [1:0] md);
    reg_write(RegImageWidth, 32'(w));
    reg_write(RegImageHeight, 32'(h));
    reg_write(RegTileColumns, 32'(tc));
    reg_write(RegTileRows, 32'(tr));
    reg_write(RegTileAlign, 32'(al));
    reg_write(RegCompCount, 32'(cc));
    reg_write(RegLayoutMode, 32'(md));
  endtask

  // Mostly in-range requests for the current geometry, some anywhere.
  task automatic random_words(int count, int w, int h);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8)
        send_word(2'($urandom_range(3)), 14'($urandom_range(h > 0 ? h - 1 : 0)),
                  14'($urandom_range(w > 0 ? w - 1 : 0)));
      else
        send_word(2'($urandom), 14'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    int w, h;
    cycle_count = 0;
    hold_cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset geometry, then field extremes per layout.
    send_word(0, 0, 0);
    send_word(3, 16383, 16383);
    send_word(2, 0, 0);
    setup(16, 8, 2, 2, 0, 4, LayoutPlanar);
    for (int m = 0; m < 3; m++) begin
      reg_write(RegLayoutMode, m);
      send_word(0, 0, 0);
      send_word(3, 7, 15);
      send_word(1, 4, 9);
      send_word(2, 8, 3);
      send_word(1, 2, 16);
    end
    drain();
    // Undefined layout, degenerate tiling, uncovered remainder, overflow.
    reg_write(RegLayoutMode, 32'(LayoutBad));
    send_word(0, 1, 1);
    setup(10, 10, 3, 0, 7, 3, LayoutPixel);
    send_word(0, 1, 1);
    setup(10, 10, 3, 3, 7, 3, LayoutPixel);
    send_word(0, 9, 2);
    send_word(0, 2, 9);
    send_word(2, 8, 8);
    setup(2, 2, 4, 1, 5, 2, LayoutRow);
    send_word(0, 0, 0);
    setup(16384, 16384, 1, 1, 65535, 4, LayoutPlanar);
    send_word(3, 16383, 16383);
    setup(16384, 16384, 16384, 16384, 65535, 4, LayoutPixel);
    send_word(3, 16383, 16383);
    send_word(0, 0, 0);
    setup(0, 5, 1, 1, 0, 0, LayoutRow);
    send_word(0, 0, 0);
    drain();

    // Random phases: idling modes cycle, geometry changes between phases.
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      if (ph == 5) hold_cycles = 300;
      if (ph == 0) begin
        setup(16384, 16384, 16384, 16384, 65535, 4, 2'($urandom_range(2)));
        w = 16384; h = 16384;
      end else if (ph == 1) begin
        setup(1, 1, 1, 1, 0, 1, LayoutPlanar);
        w = 1; h = 1;
      end else begin
        logic [14:0] tc, tr;
        tc = 15'($urandom_range(1, 64));
        tr = 15'($urandom_range(1, 64));
        w = tc * $urandom_range(1, 200) + $urandom_range(3);
        h = tr * $urandom_range(1, 200) + $urandom_range(3);
        setup(15'(w), 15'(h), tc, tr, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
              3'($urandom_range(1, 4)), 2'($urandom_range(2)));
      end
      random_words(55, w, h);
      drain();
    end

    if (errors == 0) begin
      $display("tb_tiled_interleave_source_address_unit: done, clean");
    end else begin
      $display("tb_tiled_interleave_source_address_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[tiled_interleave_source_address_unit.f]
design/tisau_pkg.sv
design/tisau_if.sv
design/tisau_cfg.sv
design/tisau_div.sv
design/tisau_addr.sv
design/tiled_interleave_source_address_unit.sv
test/tisau_checker.sv
test/tb_tiled_interleave_source_address_unit.sv
